[rtl/cft_pkg.sv]
// Package for the class tagged FIFO: sizes, function and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package cft_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 16;

  // function codes of an input item
  localparam logic [1:0] FN_ENQ      = 2'd0;
  localparam logic [1:0] FN_DEQ_C0   = 2'd1;
  localparam logic [1:0] FN_DEQ_C1   = 2'd2;
  localparam logic [1:0] FN_DEQ_ANY  = 2'd3;

  // status codes of a result
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic cmd_load;   // capture the accepted item
    logic enq;        // append at the tail, or report full
    logic find;       // register the oldest matching slot
    logic remove;     // pull the matched entry and close the gap
    logic out_load;   // move the result into the output register
  } cft_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_enq;     // captured item is an enqueue
    logic out_busy;   // output register holds a result not taken this cycle
  } cft_sts_t;

endpackage

[rtl/cft_if.sv]
// Channel interfaces of the class tagged FIFO: request and result.
// Depends on cft_pkg.
interface cft_req_if
  import cft_pkg::*;
  (input logic clk);
  logic            valid;
  logic            ready;
  logic [1:0]      func;
  logic [ID_W-1:0] entry_id;
  logic            entry_class;

  modport source (output valid, func, entry_id, entry_class, input ready);
  modport sink   (input valid, func, entry_id, entry_class, output ready);
endinterface

interface cft_rsp_if
  import cft_pkg::*;
  (input logic clk);
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [ID_W-1:0] out_id;
  logic            out_class;

  modport source (output valid, status, out_id, out_class, input ready);
  modport sink   (input valid, status, out_id, out_class, output ready);
endinterface

[rtl/class_tagged_fifo_top.sv]
// Class tagged FIFO: enqueue, or dequeue the oldest entry of a class or overall.
// Steps: capture, then append for an enqueue, or match/select and shift for a dequeue, then
// result load, which waits while the previous result is not taken on rsp ready. A new
// request is taken only after the current item's result load, so one item is handled at a time.
// Reset (synchronous, rst high) empties the queue and clears the output valid.
// Depends on cft_pkg, cft_if, cft_ctrl, cft_datapath.
module class_tagged_fifo_top
  import cft_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  cft_req_if.sink  req,
  cft_rsp_if.source rsp
);

  cft_cmd_t cmd;
  cft_sts_t sts;

  cft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cft_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (req.func),
    .entry_id    (req.entry_id),
    .entry_class (req.entry_class),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .out_id      (rsp.out_id),
    .out_class   (rsp.out_class)
  );

endmodule

[rtl/cft_datapath.sv]
// Datapath of the class tagged FIFO: shifting row of slots, occupancy,
// class match and priority select, result and output registers.
// Depends on cft_pkg.
module cft_datapath
  import cft_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cft_cmd_t        cmd,
  output cft_sts_t        sts,
  input  logic [1:0]      func,
  input  logic [ID_W-1:0] entry_id,
  input  logic            entry_class,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [ID_W-1:0] out_id,
  output logic            out_class
);

  logic [ID_W-1:0]  slot_id [DEPTH];
  logic [DEPTH-1:0] slot_cls;
  logic [OCC_W-1:0] occ;

  logic [1:0]       cur_func;
  logic [ID_W-1:0]  cur_id;
  logic             cur_cls;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] sel;
  logic             found;
  logic [DEPTH-1:0] shift_mask;
  logic             full;

  logic [ID_W-1:0]  pick_id;
  logic             pick_cls;

  logic [1:0]       res_status;
  logic [ID_W-1:0]  res_id;
  logic             res_cls;

  assign full = (occ == OCC_W'(DEPTH));

  // flag occupied slots of the requested class
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (occ > OCC_W'(i)) &&
                 ((cur_func == FN_DEQ_ANY) || (slot_cls[i] == cur_func[1]));
    end
  end

  // slots at and after the selected one move down by one
  assign shift_mask = ~(sel - DEPTH'(1));

  // read the selected entry
  always_comb begin
    pick_id  = '0;
    pick_cls = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_id  = pick_id | (sel[i] ? slot_id[i] : '0);
      pick_cls = pick_cls | (sel[i] & slot_cls[i]);
    end
  end

  // hold the captured item
  always_ff @(posedge clk) begin
    if (cmd.cmd_load) begin
      cur_func <= func;
      cur_id   <= entry_id;
      cur_cls  <= entry_class;
    end
  end

  // register the oldest match as a one-hot select
  always_ff @(posedge clk) begin
    if (cmd.find) begin
      sel   <= match & (~match + DEPTH'(1));
      found <= |match;
    end
  end

  // append or remove in the slot row
  always_ff @(posedge clk) begin
    if (cmd.enq && !full) begin
      slot_id[occ[IDX_W-1:0]]  <= cur_id;
      slot_cls[occ[IDX_W-1:0]] <= cur_cls;
    end else if (cmd.remove && found) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (shift_mask[i]) begin
          slot_id[i]  <= slot_id[i+1];
          slot_cls[i] <= slot_cls[i+1];
        end
      end
    end
  end

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.enq && !full) begin
      occ <= occ + OCC_W'(1);
    end else if (cmd.remove && found) begin
      occ <= occ - OCC_W'(1);
    end
  end

  // form the result
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      res_status <= full ? ST_FULL : ST_OK;
      res_id     <= '0;
      res_cls    <= 1'b0;
    end else if (cmd.remove) begin
      res_status <= found ? ST_OK : ST_NONE;
      res_id     <= found ? pick_id : '0;
      res_cls    <= found & pick_cls;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= res_status;
      out_id    <= res_id;
      out_class <= res_cls;
    end
  end

  assign sts.is_enq   = (cur_func == FN_ENQ);
  assign sts.out_busy = out_valid && !out_ready;

endmodule

[rtl/cft_ctrl.sv]
// Controller of the class tagged FIFO: sequences capture, find, remove
// or append, and the result transfer.
// Depends on cft_pkg.
module cft_ctrl
  import cft_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  cft_sts_t sts,
  output cft_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_REMOVE,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.cmd_load = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_enq) begin
          cmd.enq    = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.find   = 1'b1;
          state_next = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[dv/class_tagged_fifo_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for class_tagged_fifo_top: drives enqueue/dequeue requests and checks
// every result against an in-bench queue predictor. Depends on cft_pkg, cft_if.
module class_tagged_fifo_top_tb;
  import cft_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 10;
  localparam int NO_SLOT        = -1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            cls;
  } entry_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] id;
    logic            cls;
  } result_t;

  logic clk;
  logic rst;

  cft_req_if req_ch (clk);
  cft_rsp_if rsp_ch (clk);

  class_tagged_fifo_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state and expected results in arrival order
  entry_t  held_entries[$];
  result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int req_count      = 0;
  int rsp_count      = 0;
  int ok_count       = 0;
  int full_count     = 0;
  int none_count     = 0;
  int peak_occupancy = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one request to the predicted queue and return its result
  function automatic result_t compute_fifo_result(input logic [1:0] fn,
                                                  input logic [ID_W-1:0] id,
                                                  input logic cls);
    result_t r;
    int      pos;
    r   = '{status: ST_OK, id: '0, cls: 1'b0};
    pos = NO_SLOT;
    if (fn == FN_ENQ) begin
      if (held_entries.size() >= DEPTH) r.status = ST_FULL;
      else held_entries.push_back('{id: id, cls: cls});
    end else begin
      // oldest entry of the requested class, or oldest overall
      foreach (held_entries[i]) begin
        if (pos == NO_SLOT &&
            (fn == FN_DEQ_ANY || held_entries[i].cls == (fn == FN_DEQ_C1)))
          pos = i;
      end
      if (pos == NO_SLOT) begin
        r.status = ST_NONE;
      end else begin
        r.id  = held_entries[pos].id;
        r.cls = held_entries[pos].cls;
        held_entries.delete(pos);
      end
    end
    return r;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // predict on each request transfer, check each result transfer
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        pending_results.push_back(compute_fifo_result(req_ch.func, req_ch.entry_id,
                                                      req_ch.entry_class));
        req_count++;
        if (held_entries.size() > peak_occupancy) peak_occupancy = held_entries.size();
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{status: rsp_ch.status, id: rsp_ch.out_id, cls: rsp_ch.out_class};
        rsp_count++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d id %h class %0b",
                                    got.status, got.id, got.cls));
        end else begin
          want = pending_results.pop_front();
          case (want.status)
            ST_OK:   ok_count++;
            ST_FULL: full_count++;
            default: none_count++;
          endcase
          if (got.status !== want.status || got.id !== want.id || got.cls !== want.cls)
            report_mismatch($sformatf(
              "result %0d: expected status %0d id %h class %0b, got status %0d id %h class %0b",
              rsp_count, want.status, want.id, want.cls, got.status, got.id, got.cls));
        end
      end
    end
  end

  // drive result ready: long hold when requested, else random stalls
  initial begin : result_receiver
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // end the run when nothing transfers for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // offer one request, with random idle cycles ahead, and wait for its transfer
  task automatic send_item(input logic [1:0] fn, input logic [ID_W-1:0] id,
                           input logic cls);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= fn;
    req_ch.entry_id    <= id;
    req_ch.entry_class <= cls;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // empty-queue misses, class misses, removal from head and middle
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(FN_DEQ_ANY, 16'hFFFF, 1'b1);
    send_item(FN_DEQ_C0,  16'hFFFF, 1'b1);
    send_item(FN_DEQ_C1,  16'hFFFF, 1'b0);
    send_item(FN_ENQ,     16'hFFFF, 1'b1);
    send_item(FN_DEQ_C0,  16'h0000, 1'b0);
    send_item(FN_ENQ,     16'h0000, 1'b0);
    send_item(FN_ENQ,     16'hA5A5, 1'b1);
    send_item(FN_ENQ,     16'h5A5A, 1'b0);
    send_item(FN_DEQ_C0,  16'hFFFF, 1'b1);
    send_item(FN_DEQ_C1,  16'h0000, 1'b0);
    send_item(FN_DEQ_ANY, 16'hFFFF, 1'b1);
    send_item(FN_DEQ_C1,  16'hFFFF, 1'b1);
    send_item(FN_DEQ_ANY, 16'h0000, 1'b0);
  endtask

  // overfill, remove by each function, refill, then drain past empty
  task automatic test_full_queue();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DEPTH + 2) send_item(FN_ENQ, ID_W'($urandom), 1'($urandom));
    send_item(FN_DEQ_C0,  ID_W'($urandom), 1'($urandom));
    send_item(FN_DEQ_C1,  ID_W'($urandom), 1'($urandom));
    send_item(FN_DEQ_ANY, ID_W'($urandom), 1'($urandom));
    repeat (4) send_item(FN_ENQ, ID_W'($urandom), 1'($urandom));
    repeat (DEPTH + 2) send_item(FN_DEQ_ANY, ID_W'($urandom), 1'($urandom));
  endtask

  // random mix that swings between filling and draining the queue
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    logic [1:0]      fn;
    logic [ID_W-1:0] id;
    int              enq_bias;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    enq_bias       = 70;
    for (int k = 0; k < n_items; k++) begin
      if (k % 32 == 31) enq_bias = 100 - enq_bias;
      if ($urandom_range(99) < enq_bias) fn = FN_ENQ;
      else fn = 2'($urandom_range(3, 1));
      case ($urandom_range(15))
        0:       id = '0;
        1:       id = '1;
        default: id = ID_W'($urandom);
      endcase
      send_item(fn, id, 1'($urandom));
    end
  endtask

  // hold off the receiver while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    for (int k = 0; k < 60; k++) begin
      if (k % 3 == 0) send_item(2'($urandom_range(3, 1)), ID_W'($urandom), 1'($urandom));
      else send_item(FN_ENQ, ID_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin : main_seq
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= FN_ENQ;
    req_ch.entry_id    <= '0;
    req_ch.entry_class <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_queue();
    test_random_traffic(0,  0,  440);
    test_random_traffic(48, 0,  440);
    test_random_traffic(0,  48, 440);
    test_random_traffic(10, 10, 440);
    test_output_backpressure();
    req_ch.valid <= 1'b0;

    // drain outstanding results, then allow for the pipeline latency
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Run covered %0d requests and %0d results: %0d ok, %0d full, %0d no match.",
             req_count, rsp_count, ok_count, full_count, none_count);
    $display("Peak occupancy %0d of %0d; %0d mismatches.",
             peak_occupancy, DEPTH, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
